// File: sv/stc_pkg.sv
// Shared types and constants of the slot table with first-free insert.
// Used by the slot evaluator and the top level; depends on nothing.
`default_nettype none

package stc_pkg;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	localparam logic [15:0] CHEAP_LIMIT_RESET = 16'd300;
	localparam logic [4:0]  COUNT_MAX         = 5'd31;

	// One stored slot. The extra word holds payload one in its low half.
	typedef struct packed {
		logic [15:0] key;
		logic [15:0] price;
		logic [31:0] extra;
	} entry_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] item_key;
		logic [15:0] item_price;
		logic [15:0] payload_one;
		logic [15:0] payload_two;
	} cmd_t;

	typedef struct packed {
		logic        success;
		logic [15:0] removed_key;
		logic [15:0] removed_price;
		logic [15:0] removed_word_one;
		logic [15:0] removed_word_two;
		logic [4:0]  cheap_count;
	} rsp_t;

	// Verdict of the slot evaluator on one entry.
	typedef struct packed {
		logic match;
		logic cheap;
	} eval_t;

endpackage

`default_nettype wire

// File: sv/stc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Stand-alone; no package needed.
`default_nettype none

module stc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: sv/stc_eval.sv
// Shared slot evaluator: key compare and price-limit compare on one entry.
// Depends on stc_pkg for the entry and verdict types.
`default_nettype none

module stc_eval import stc_pkg::*; (
	input  wire entry_t      entry,
	input  wire logic [15:0] target_key,
	input  wire logic [15:0] limit,
	output eval_t            verdict
);

	always_comb begin
		verdict.match = (entry.key == target_key);
		// Only occupied slots count toward the cheap total.
		verdict.cheap = (entry.key != 16'd0) && (entry.price <= limit);
	end

endmodule

`default_nettype wire

// File: sv/slot_table_insert_remove_count.sv
// Slot table with first-free insert, remove by key and a count of cheap occupied slots.
// An accepted command (start high while busy is low) scans all SLOTS slots through one
// shared evaluator reading the slot RAM one entry per cycle, then writes the chosen slot in
// a write state. The result appears on rsp with done high for one cycle, and busy falls in
// that same cycle, so a new command can be issued from that cycle on; the receiver must
// take the result when done is high. After reset the block clears every slot of the RAM
// with busy high. The price limit register may be written at any time the block is not
// busy; cfg_ready is always high.
`default_nettype none

module slot_table_insert_remove_count import stc_pkg::*; #(
	parameter int SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire cmd_t        cmd,
	output logic             done,
	output rsp_t             rsp,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_WRITE
	} state_t;

	state_t          state_q;
	cmd_t            cmd_q;
	logic [15:0]     limit_q;
	logic [AW-1:0]   ra_q;
	logic            issue_done_q;
	logic            dv_s1;
	logic [AW-1:0]   di_s1;
	logic            found_q;
	logic [AW-1:0]   fidx_q;
	entry_t          fent_q;
	logic [CW-1:0]   count_q;
	logic            done_q;
	rsp_t            rsp_q;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [63:0]     ram_wdata;
	logic [63:0]     ram_rdata;
	entry_t          rd_entry;
	entry_t          new_entry;
	entry_t          eval_entry;
	logic [15:0]     target_key;
	eval_t           verdict;
	logic [CW-1:0]   final_count;
	logic [4:0]      sat_count;

	assign rd_entry = entry_t'(ram_rdata);

	always_comb begin
		new_entry.key   = cmd_q.item_key;
		new_entry.price = cmd_q.item_price;
		new_entry.extra = {cmd_q.payload_two, cmd_q.payload_one};
	end

	// During the scan the evaluator sees each stored slot; in the write cycle it judges
	// the entry that enters or leaves, so the count can be corrected.
	always_comb begin
		if (state_q == S_WRITE) begin
			eval_entry = (cmd_q.op == OP_INSERT) ? new_entry : fent_q;
		end else begin
			eval_entry = rd_entry;
		end
		target_key = (cmd_q.op == OP_INSERT) ? 16'd0 : cmd_q.item_key;
	end

	stc_eval u_eval (
		.entry      (eval_entry),
		.target_key (target_key),
		.limit      (limit_q),
		.verdict    (verdict)
	);

	always_comb begin
		final_count = count_q;
		if (found_q && verdict.cheap) begin
			if (cmd_q.op == OP_INSERT) begin
				final_count = count_q + CW'(1);
			end else begin
				final_count = count_q - CW'(1);
			end
		end
		if (32'(final_count) > 32'(COUNT_MAX)) begin
			sat_count = COUNT_MAX;
		end else begin
			sat_count = 5'(final_count);
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ra_q;
		ram_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_WRITE: begin
				ram_we    = found_q;
				ram_waddr = fidx_q;
				if (cmd_q.op == OP_INSERT) begin
					ram_wdata = 64'(new_entry);
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	stc_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ra_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= CHEAP_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			cmd_q        <= '0;
			ra_q         <= '0;
			issue_done_q <= 1'b0;
			dv_s1        <= 1'b0;
			di_s1        <= '0;
			found_q      <= 1'b0;
			fidx_q       <= '0;
			fent_q       <= '0;
			count_q      <= '0;
			done_q       <= 1'b0;
			rsp_q        <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (ra_q == LAST) begin
						ra_q    <= '0;
						state_q <= S_IDLE;
					end else begin
						ra_q <= ra_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q        <= cmd;
						ra_q         <= '0;
						issue_done_q <= 1'b0;
						dv_s1        <= 1'b0;
						found_q      <= 1'b0;
						count_q      <= '0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					// Evaluation of a slot follows in the cycle after its read is issued.
					dv_s1 <= !issue_done_q;
					di_s1 <= ra_q;
					if (!issue_done_q) begin
						if (ra_q == LAST) begin
							issue_done_q <= 1'b1;
						end else begin
							ra_q <= ra_q + AW'(1);
						end
					end
					if (dv_s1) begin
						count_q <= count_q + CW'(verdict.cheap);
						if (verdict.match && !found_q) begin
							found_q <= 1'b1;
							fidx_q  <= di_s1;
							fent_q  <= rd_entry;
						end
						if (di_s1 == LAST) begin
							state_q <= S_WRITE;
						end
					end
				end
				S_WRITE: begin
					rsp_q.success     <= found_q;
					rsp_q.cheap_count <= sat_count;
					if (found_q && (cmd_q.op == OP_REMOVE)) begin
						rsp_q.removed_key      <= fent_q.key;
						rsp_q.removed_price    <= fent_q.price;
						rsp_q.removed_word_one <= fent_q.extra[15:0];
						rsp_q.removed_word_two <= fent_q.extra[31:16];
					end else begin
						rsp_q.removed_key      <= '0;
						rsp_q.removed_price    <= '0;
						rsp_q.removed_word_one <= '0;
						rsp_q.removed_word_two <= '0;
					end
					done_q  <= 1'b1;
					ra_q    <= '0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	// A result only follows a command that was in progress.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a command in progress");

	// An accepted command keeps the block busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after accepting a command");

	// A failed transaction never returns entry contents.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.success) |-> (rsp.removed_key == 16'd0 && rsp.removed_price == 16'd0
			&& rsp.removed_word_one == 16'd0 && rsp.removed_word_two == 16'd0))
		else $error("failed transaction returned entry data");

	// The cheap count cannot exceed the number of slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(rsp.cheap_count) <= SLOTS))
		else $error("cheap count above table size");

endmodule

`default_nettype wire
